[src/spi_bridge_transaction_sequencer_unit_macros.svh]
// assertion macros for the sequencer checker
`ifndef SPI_BRIDGE_TRANSACTION_SEQUENCER_UNIT_MACROS_SVH
`define SPI_BRIDGE_TRANSACTION_SEQUENCER_UNIT_MACROS_SVH

// property checked on every clock edge outside reset
`define SBTS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every clock edge outside reset
`define SBTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define SBTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/sbts_pkg.sv]
package sbts_pkg;

  localparam int ADDR_WIDTH   = 13;
  localparam int ADDR_FIELD_W = 13;
  localparam int CFG_IDX_W    = 1;

  localparam logic [2:0] ACT_SINGLE     = 3'd0;
  localparam logic [2:0] ACT_VERIFY_WR  = 3'd1;
  localparam logic [2:0] ACT_CHIP_WRITE = 3'd2;
  localparam logic [2:0] ACT_CHIP_READ  = 3'd3;
  localparam logic [2:0] ACT_REPLY      = 3'd4;

  localparam logic [1:0] MEM_WAVE = 2'd0;
  localparam logic [1:0] MEM_RAM  = 2'd1;
  localparam logic [1:0] MEM_TXC  = 2'd2;
  localparam logic [1:0] MEM_USER = 2'd3;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_VFY_FAIL = 3'd1;
  localparam logic [2:0] STAT_BUSY     = 3'd2;
  localparam logic [2:0] STAT_TMO1     = 3'd3;
  localparam logic [2:0] STAT_TMO2     = 3'd4;
  localparam logic [2:0] STAT_MISMATCH = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_TRIES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT  = 1'd1;

  localparam logic [3:0] WRITE_TRIES_RST = 4'd3;
  localparam logic [3:0] POLL_LIMIT_RST  = 4'd3;

  // bridge register map in user memory
  localparam logic [ADDR_FIELD_W-1:0] USR_STATUS = 13'd2;
  localparam logic [ADDR_FIELD_W-1:0] USR_CADDR  = 13'd4;
  localparam logic [ADDR_FIELD_W-1:0] USR_DATA   = 13'd5;
  localparam logic [7:0]              BRG_GO     = 8'd2;

  typedef struct packed {
    logic [2:0]              action;
    logic [1:0]              mem_select;
    logic                    write_flag;
    logic                    ram_half;
    logic [ADDR_FIELD_W-1:0] address;
    logic [7:0]              data_byte;
    logic [7:0]              reply_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] frame;
    logic        frame_valid;
    logic        done_res;
    logic [2:0]  status;
    logic [7:0]  read_data;
  } out_item_t;

  typedef struct packed {
    logic [3:0] write_tries;
    logic [3:0] poll_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]              mem;
    logic                    wr;
    logic                    half;
    logic [ADDR_FIELD_W-1:0] addr;
    logic [7:0]              data;
  } frame_req_t;

endpackage

[src/sbts_frame_build.sv]
module sbts_frame_build (
  input  sbts_pkg::frame_req_t req,
  output logic [31:0]          frame
);

  logic [22:0] word;

  always_comb begin
    word = '0;
    case (req.mem)
      sbts_pkg::MEM_WAVE: begin
        word[21]    = 1'b1;
        word[20:8]  = req.addr[12:0];
      end
      sbts_pkg::MEM_RAM: begin
        word[22]    = req.wr;
        word[20]    = 1'b1;
        word[17]    = req.half;
        word[16:8]  = req.addr[8:0];
      end
      sbts_pkg::MEM_TXC: begin
        word[22]    = req.wr;
        word[19]    = 1'b1;
        word[17:8]  = req.addr[9:0];
      end
      default: begin
        word[22]    = req.wr;
        word[18]    = 1'b1;
        word[10:8]  = req.addr[2:0];
      end
    endcase
    word[7:0] = req.data;
  end

  assign frame = {word, 9'd0};

endmodule

[src/sbts_script.sv]
module sbts_script #(
  parameter int ADDR_WIDTH = sbts_pkg::ADDR_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  sbts_pkg::in_item_t   item,
  input  sbts_pkg::cfg_t       cfg,
  output sbts_pkg::out_item_t  result
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SINGLE, ST_VW_WRITE, ST_VW_READ, ST_BUSY, ST_ADDR1, ST_DATA1, ST_GO1,
    ST_POLL1, ST_CLR1, ST_ADDR2, ST_DATA2, ST_GO2, ST_POLL2, ST_CLR2, ST_RTRN
  } step_e;

  step_e                 step_r, step_nxt;
  logic [1:0]            kind_r, kind_nxt;
  logic [3:0]            try_r, try_nxt;
  logic [3:0]            poll_r, poll_nxt;
  logic [1:0]            mem_r, mem_nxt;
  logic                  wr_r, wr_nxt;
  logic                  half_r, half_nxt;
  logic [ADDR_WIDTH-1:0] addr_r, addr_nxt;
  logic [7:0]            data_r, data_nxt;

  logic                  fin;
  logic                  live;
  logic [2:0]            stat;
  logic [3:0]            tries;
  logic [7:0]            rb;
  logic [6:0]            chip_addr;
  sbts_pkg::frame_req_t  req;
  logic [31:0]           frame;

  assign tries     = (cfg.write_tries == 4'd0) ? 4'd1 : cfg.write_tries;
  assign rb        = item.reply_byte;
  assign chip_addr = addr_nxt[6:0];

  always_comb begin
    step_nxt = step_r;
    kind_nxt = kind_r;
    try_nxt  = try_r;
    poll_nxt = poll_r;
    mem_nxt  = mem_r;
    wr_nxt   = wr_r;
    half_nxt = half_r;
    addr_nxt = addr_r;
    data_nxt = data_r;
    fin      = 1'b0;
    live     = 1'b0;
    stat     = sbts_pkg::STAT_OK;
    if (item.action <= sbts_pkg::ACT_CHIP_READ) begin
      live     = 1'b1;
      mem_nxt  = item.mem_select;
      wr_nxt   = item.write_flag;
      half_nxt = item.ram_half;
      addr_nxt = ADDR_WIDTH'(item.address);
      data_nxt = (item.action == sbts_pkg::ACT_CHIP_READ) ? 8'd0 : item.data_byte;
      kind_nxt = item.action[1:0];
      try_nxt  = 4'd0;
      poll_nxt = 4'd0;
      case (item.action)
        sbts_pkg::ACT_SINGLE:     step_nxt = ST_SINGLE;
        sbts_pkg::ACT_VERIFY_WR:  step_nxt = ST_VW_WRITE;
        sbts_pkg::ACT_CHIP_WRITE: step_nxt = ST_BUSY;
        default:                  step_nxt = ST_ADDR2;
      endcase
    end else if (item.action == sbts_pkg::ACT_REPLY && step_r != ST_IDLE) begin
      live = 1'b1;
      case (step_r)
        ST_SINGLE:   fin = 1'b1;
        ST_VW_WRITE: step_nxt = ST_VW_READ;
        ST_VW_READ: begin
          if (rb == data_r) begin
            fin = 1'b1;
          end else if (({1'b0, try_r} + 5'd1) >= {1'b0, tries}) begin
            fin  = 1'b1;
            stat = sbts_pkg::STAT_VFY_FAIL;
          end else begin
            try_nxt  = try_r + 4'd1;
            step_nxt = ST_VW_WRITE;
          end
        end
        ST_BUSY: begin
          if (rb[6:5] != 2'b00) begin
            fin  = 1'b1;
            stat = sbts_pkg::STAT_BUSY;
          end else begin
            step_nxt = ST_ADDR1;
          end
        end
        ST_POLL1, ST_POLL2: begin
          if (rb[5]) begin
            poll_nxt = 4'd0;
            step_nxt = (step_r == ST_POLL1) ? ST_CLR1 : ST_CLR2;
          end else if (poll_r >= cfg.poll_limit) begin
            fin  = 1'b1;
            stat = (step_r == ST_POLL1 || kind_r == sbts_pkg::ACT_CHIP_READ[1:0]) ?
                   sbts_pkg::STAT_TMO1 : sbts_pkg::STAT_TMO2;
          end else begin
            poll_nxt = poll_r + 4'd1;
          end
        end
        ST_RTRN: begin
          fin  = 1'b1;
          stat = (kind_r == sbts_pkg::ACT_CHIP_WRITE[1:0] && rb != data_r) ?
                 sbts_pkg::STAT_MISMATCH : sbts_pkg::STAT_OK;
        end
        ST_ADDR1: step_nxt = ST_DATA1;
        ST_DATA1: step_nxt = ST_GO1;
        ST_GO1:   step_nxt = ST_POLL1;
        ST_CLR1:  step_nxt = ST_ADDR2;
        ST_ADDR2: step_nxt = ST_DATA2;
        ST_DATA2: step_nxt = ST_GO2;
        ST_GO2:   step_nxt = ST_POLL2;
        ST_CLR2:  step_nxt = ST_RTRN;
        default:  fin = 1'b1;
      endcase
      if (fin) begin
        step_nxt = ST_IDLE;
      end
    end
  end

  // frame request for the step being entered
  always_comb begin
    req      = '0;
    req.mem  = sbts_pkg::MEM_USER;
    req.addr = sbts_pkg::USR_DATA;
    case (step_nxt)
      ST_SINGLE, ST_VW_WRITE, ST_VW_READ: begin
        req.mem  = mem_nxt;
        req.half = half_nxt;
        req.addr = sbts_pkg::ADDR_FIELD_W'(addr_nxt);
        req.wr   = (step_nxt == ST_SINGLE) ? wr_nxt : (step_nxt == ST_VW_WRITE);
        req.data = (step_nxt == ST_VW_READ) ? 8'd0 : data_nxt;
      end
      ST_BUSY, ST_POLL1, ST_POLL2: req.addr = sbts_pkg::USR_STATUS;
      ST_ADDR1, ST_ADDR2: begin
        req.wr   = 1'b1;
        req.addr = sbts_pkg::USR_CADDR;
        req.data = {step_nxt == ST_ADDR1, chip_addr};
      end
      ST_DATA1, ST_DATA2: begin
        req.wr   = 1'b1;
        req.data = data_nxt;
      end
      ST_GO1, ST_GO2: begin
        req.wr   = 1'b1;
        req.addr = sbts_pkg::USR_STATUS;
        req.data = sbts_pkg::BRG_GO;
      end
      ST_CLR1, ST_CLR2: begin
        req.wr   = 1'b1;
        req.addr = sbts_pkg::USR_STATUS;
      end
      default: req.wr = 1'b0;
    endcase
  end

  sbts_frame_build u_frame (
    .req   (req),
    .frame (frame)
  );

  always_comb begin
    result = '0;
    if (fin) begin
      result.done_res  = 1'b1;
      result.status    = stat;
      result.read_data = rb;
    end else if (live) begin
      result.frame       = frame;
      result.frame_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
      kind_r <= 2'd0;
      try_r  <= 4'd0;
      poll_r <= 4'd0;
      mem_r  <= 2'd0;
      wr_r   <= 1'b0;
      half_r <= 1'b0;
      addr_r <= '0;
      data_r <= 8'd0;
    end else if (en) begin
      step_r <= step_nxt;
      kind_r <= kind_nxt;
      try_r  <= try_nxt;
      poll_r <= poll_nxt;
      mem_r  <= mem_nxt;
      wr_r   <= wr_nxt;
      half_r <= half_nxt;
      addr_r <= addr_nxt;
      data_r <= data_nxt;
    end
  end

endmodule

[src/spi_bridge_transaction_sequencer_unit.sv]
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall  sbts_pkg::in_item_t
// out_      output     out_valid/out_stall  sbts_pkg::out_item_t
// cfg_      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one item per cycle unless out_stall holds the result register; a transferred item passes through
// the input register, then script logic into the result register
// every input item gives exactly one result item
// rst_n is synchronous; it empties both registers and restores the script and config
// out_stall holds the result register and backs up into in_stall
module spi_bridge_transaction_sequencer_unit #(
  parameter int ADDR_WIDTH = sbts_pkg::ADDR_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  sbts_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output sbts_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sbts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [3:0]                         cfg_data
);

  logic                in_vld_r;
  sbts_pkg::in_item_t  in_item_r;
  logic                out_vld_r;
  sbts_pkg::out_item_t out_item_r;
  sbts_pkg::cfg_t      cfg_r;
  sbts_pkg::out_item_t result;
  logic                adv;
  logic                step_en;

  assign adv       = !out_vld_r || !out_stall;
  assign in_stall  = in_vld_r && !adv;
  assign step_en   = in_vld_r && adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  sbts_script #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_script (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (step_en),
    .item   (in_item_r),
    .cfg    (cfg_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r          <= 1'b0;
      out_vld_r         <= 1'b0;
      cfg_r.write_tries <= sbts_pkg::WRITE_TRIES_RST;
      cfg_r.poll_limit  <= sbts_pkg::POLL_LIMIT_RST;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= in_vld_r;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sbts_pkg::CFG_WRITE_TRIES: cfg_r.write_tries <= cfg_data;
          sbts_pkg::CFG_POLL_LIMIT:  cfg_r.poll_limit  <= cfg_data;
          default: cfg_r <= cfg_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
    if (step_en) begin
      out_item_r <= result;
    end
  end

endmodule

[src/sbts_checker.sv]
`include "spi_bridge_transaction_sequencer_unit_macros.svh"

module sbts_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input sbts_pkg::out_item_t out_data
);

  `SBTS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")
  `SBTS_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data), "stalled result changed")
  `SBTS_ASSERT(a_kind_excl, clk, rst_n, !(out_valid && out_data.frame_valid && out_data.done_res), "frame and done together")
  `SBTS_ASSERT_IMP(a_done_clean, clk, rst_n, out_valid && out_data.done_res, out_data.frame == 32'd0, "done result carries a frame")

endmodule

bind spi_bridge_transaction_sequencer_unit sbts_checker u_sbts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
